### src/swd_pkg.sv
// Shared types, constants and helpers of the SWD host transaction engine.
`default_nettype none
package swd_pkg;

	localparam int unsigned QUEUE_DEPTH     = 2;
	localparam int unsigned HDR_BITS        = 8;
	localparam int unsigned ACK_BITS        = 3;
	localparam int unsigned DATA_BITS       = 32;
	localparam int unsigned HIGH_W          = 7;
	localparam int unsigned IDLE_W          = 4;
	localparam int unsigned CNT_W           = 7;
	localparam int unsigned CFG_DATA_W      = 7;

	localparam logic [HIGH_W-1:0]   MIN_HIGH_RUN   = 7'd50;
	localparam logic [HIGH_W-1:0]   HIGH_RESET     = 7'd56;
	localparam logic [IDLE_W-1:0]   IDLE_RESET     = 4'd2;
	localparam logic [ACK_BITS-1:0] ACK_OK         = 3'b001;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_TXN   = 2'd1,
		KIND_LRST  = 2'd2,
		KIND_SPARE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_TXN,
		OP_LRST,
		OP_NONE
	} op_t;

	typedef enum logic {
		CFG_HIGH_RUN = 1'b0,
		CFG_IDLE_RUN = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_HDR    = 4'd1,
		PH_TRN1   = 4'd2,
		PH_ACK    = 4'd3,
		PH_TRN2   = 4'd4,
		PH_WDATA  = 4'd5,
		PH_WPAR   = 4'd6,
		PH_RDATA  = 4'd7,
		PH_RPAR   = 4'd8,
		PH_TRNEND = 4'd9,
		PH_LRH    = 4'd10,
		PH_LRL    = 4'd11
	} phase_t;

	typedef struct packed {
		op_t                  op;
		logic [HDR_BITS-1:0]  header;
		logic [DATA_BITS-1:0] wdata;
		logic                 wpar;
		logic                 rnw;
		logic                 sampled;
	} entry_t;

	typedef struct packed {
		logic                 drive_bit;
		logic                 drive_enable;
		logic                 clock_active;
		logic                 busy_res;
		logic                 done_res;
		logic [ACK_BITS-1:0]  ack_code;
		logic [DATA_BITS-1:0] rd_word;
		logic                 parity_error;
		logic                 rejected;
	} result_t;

endpackage
`default_nettype wire

### src/swd_front.sv
// Request decode and transfer queue in front of the SWD engine.
`default_nettype none
module swd_front
	import swd_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           kind,
	input  wire logic                 ap_not_dp,
	input  wire logic                 read_not_write,
	input  wire logic [1:0]           reg_addr,
	input  wire logic [DATA_BITS-1:0] wr_word,
	input  wire logic                 sampled_bit,
	output logic                      q_valid,
	output entry_t                    q_entry,
	input  wire logic                 q_pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

	entry_t              slot_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_QW-1:0]   count_q;
	entry_t              entry_in;
	logic                push;
	logic                hdr_par;

	always_comb begin
		hdr_par = ap_not_dp ^ read_not_write ^ reg_addr[0] ^ reg_addr[1];
		entry_in.header  = {1'b1, 1'b0, hdr_par, reg_addr, read_not_write, ap_not_dp, 1'b1};
		entry_in.wdata   = wr_word;
		entry_in.wpar    = ^wr_word;
		entry_in.rnw     = read_not_write;
		entry_in.sampled = sampled_bit;
		case (kind_t'(kind))
			KIND_TICK: entry_in.op = OP_TICK;
			KIND_TXN:  entry_in.op = OP_TXN;
			KIND_LRST: entry_in.op = OP_LRST;
			default:   entry_in.op = OP_NONE;
		endcase
	end

	assign in_stall = (count_q == FULL_CNT);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/swd_back.sv
// SWD engine: phase sequencer, shift registers and result register.
`default_nettype none
module swd_back
	import swd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  q_valid,
	input  entry_t                     q_entry,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output result_t                    res
);

	logic [HIGH_W-1:0]    high_cfg_q;
	logic [IDLE_W-1:0]    idle_cfg_q;

	phase_t               phase_q,  phase_n;
	logic [CNT_W-1:0]     cnt_q,    cnt_n;
	logic [HDR_BITS-1:0]  hdr_q,    hdr_n;
	logic [DATA_BITS-1:0] data_q,   data_n;
	logic                 par_q,    par_n;
	logic [ACK_BITS-1:0]  ack_q,    ack_n;
	logic                 rd_q,     rd_n;

	result_t              res_n;
	result_t              res_q;
	logic                 out_valid_q;

	logic                 busy;
	logic                 tick;
	logic [CNT_W:0]       cnt_inc;
	logic [HIGH_W-1:0]    high_run;
	logic                 s;

	function automatic logic [1:0] present(phase_t ph, logic h0, logic d0, logic p);
		case (ph)
			PH_HDR:    present = {h0, 1'b1};
			PH_WDATA:  present = {d0, 1'b1};
			PH_WPAR:   present = {p, 1'b1};
			PH_LRH:    present = 2'b11;
			PH_TRN1, PH_ACK, PH_TRN2, PH_RDATA, PH_RPAR, PH_TRNEND:
			           present = 2'b00;
			default:   present = 2'b01;
		endcase
	endfunction

	assign busy     = (phase_q != PH_IDLE);
	assign tick     = (q_entry.op == OP_TICK) && busy;
	assign s        = q_entry.sampled;
	assign cnt_inc  = {1'b0, cnt_q} + 1'b1;
	assign high_run = (high_cfg_q < MIN_HIGH_RUN) ? MIN_HIGH_RUN : high_cfg_q;
	assign q_pop    = q_valid && (!out_valid_q || !out_stall);

	// next state and datapath
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		hdr_n   = hdr_q;
		data_n  = data_q;
		par_n   = par_q;
		ack_n   = ack_q;
		rd_n    = rd_q;
		if (tick) begin
			case (phase_q)
				PH_HDR: begin
					hdr_n = hdr_q >> 1;
					cnt_n = cnt_inc[CNT_W-1:0];
					if (cnt_inc >= (CNT_W+1)'(HDR_BITS)) begin
						phase_n = PH_TRN1;
						cnt_n   = '0;
					end
				end
				PH_TRN1: begin
					phase_n = PH_ACK;
					cnt_n   = '0;
					ack_n   = '0;
				end
				PH_ACK: begin
					if (cnt_q[1:0] < 2'(ACK_BITS)) begin
						ack_n[cnt_q[1:0]] = ack_q[cnt_q[1:0]] | s;
					end
					cnt_n = cnt_inc[CNT_W-1:0];
					if (cnt_inc >= (CNT_W+1)'(ACK_BITS)) begin
						cnt_n = '0;
						if (ack_n != ACK_OK) begin
							phase_n = PH_TRNEND;
						end else if (rd_q) begin
							phase_n = PH_RDATA;
							data_n  = '0;
							par_n   = 1'b0;
						end else begin
							phase_n = PH_TRN2;
						end
					end
				end
				PH_TRN2: begin
					phase_n = PH_WDATA;
					cnt_n   = '0;
				end
				PH_WDATA: begin
					data_n = data_q >> 1;
					cnt_n  = cnt_inc[CNT_W-1:0];
					if (cnt_inc >= (CNT_W+1)'(DATA_BITS)) begin
						phase_n = PH_WPAR;
						cnt_n   = '0;
					end
				end
				PH_WPAR:   phase_n = PH_IDLE;
				PH_RDATA: begin
					data_n = {s, data_q[DATA_BITS-1:1]};
					par_n  = par_q ^ s;
					cnt_n  = cnt_inc[CNT_W-1:0];
					if (cnt_inc >= (CNT_W+1)'(DATA_BITS)) begin
						phase_n = PH_RPAR;
						cnt_n   = '0;
					end
				end
				PH_RPAR: begin
					par_n   = par_q ^ s;
					phase_n = PH_TRNEND;
				end
				PH_TRNEND: phase_n = PH_IDLE;
				PH_LRH: begin
					cnt_n = cnt_inc[CNT_W-1:0];
					if (cnt_inc >= {1'b0, high_run}) begin
						cnt_n   = '0;
						phase_n = (idle_cfg_q == '0) ? PH_IDLE : PH_LRL;
					end
				end
				PH_LRL: begin
					cnt_n = cnt_inc[CNT_W-1:0];
					if (cnt_inc >= (CNT_W+1)'(idle_cfg_q)) begin
						cnt_n   = '0;
						phase_n = PH_IDLE;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end else if (!busy && q_entry.op == OP_TXN) begin
			hdr_n   = q_entry.header;
			data_n  = q_entry.wdata;
			par_n   = q_entry.wpar;
			ack_n   = '0;
			rd_n    = q_entry.rnw;
			cnt_n   = '0;
			phase_n = PH_HDR;
		end else if (!busy && q_entry.op == OP_LRST) begin
			hdr_n   = '0;
			ack_n   = '0;
			par_n   = 1'b0;
			rd_n    = 1'b0;
			cnt_n   = '0;
			phase_n = PH_LRH;
		end
	end

	// result of this step
	always_comb begin
		if (tick) begin
			{res_n.drive_bit, res_n.drive_enable} = present(phase_q, hdr_q[0], data_q[0], par_q);
		end else begin
			{res_n.drive_bit, res_n.drive_enable} = present(phase_n, hdr_n[0], data_n[0], par_n);
		end
		res_n.clock_active = tick;
		res_n.busy_res     = (phase_n != PH_IDLE);
		res_n.done_res     = tick && (phase_n == PH_IDLE);
		res_n.ack_code     = res_n.done_res ? ack_q : '0;
		res_n.parity_error = 1'b0;
		res_n.rd_word      = '0;
		if (tick && phase_q == PH_TRNEND && ack_q == ACK_OK && rd_q) begin
			res_n.parity_error = par_q;
			res_n.rd_word      = par_q ? '0 : data_q;
		end
		res_n.rejected     = busy && (q_entry.op == OP_TXN || q_entry.op == OP_LRST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_cfg_q <= HIGH_RESET;
			idle_cfg_q <= IDLE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_HIGH_RUN: high_cfg_q <= cfg_data[HIGH_W-1:0];
				CFG_IDLE_RUN: idle_cfg_q <= cfg_data[IDLE_W-1:0];
				default:      high_cfg_q <= high_cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			hdr_q       <= '0;
			data_q      <= '0;
			par_q       <= 1'b0;
			ack_q       <= '0;
			rd_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				hdr_q   <= hdr_n;
				data_q  <= data_n;
				par_q   <= par_n;
				ack_q   <= ack_n;
				rd_q    <= rd_n;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && res_n.done_res |=> phase_q == PH_IDLE)
		else $error("done without return to idle");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && res_n.rejected |=> phase_q == $past(phase_q))
		else $error("rejected request changed the phase");

	a_idle_noclk: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && phase_q == PH_IDLE |-> !res_n.clock_active && !res_n.done_res)
		else $error("clock cycle produced while idle");

	a_perr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && res_n.parity_error |-> res_n.rd_word == '0 && res_n.done_res)
		else $error("parity error with non-zero read word");

endmodule
`default_nettype wire

### src/swd_host_transaction_engine_core.sv
// Top level of the SWD host transaction engine.
// Serial Wire Debug host, one SWCLK bit period per transfer on the input channel. Each input
// transfer (clock tick, transaction start or line reset start) yields exactly one result
// transfer carrying the SWDIO drive level, drive enable and status. One transfer is taken
// per clock cycle unless out_stall is held: the phase register advances once per transfer.
// A transfer passes through a request queue (QUEUE_DEPTH entries) and the result register.
// Configuration writes must be made only while the engine is idle; the block itself does not
// enforce this. Index 0 sets the line reset high run, index 1 the idle low run.
`default_nettype none
module swd_host_transaction_engine_core
	import swd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            kind,
	input  wire logic                  ap_not_dp,
	input  wire logic                  read_not_write,
	input  wire logic [1:0]            reg_addr,
	input  wire logic [DATA_BITS-1:0]  wr_word,
	input  wire logic                  sampled_bit,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       drive_bit,
	output logic                       drive_enable,
	output logic                       clock_active,
	output logic                       busy_res,
	output logic                       done_res,
	output logic [ACK_BITS-1:0]        ack_code,
	output logic [DATA_BITS-1:0]       rd_word,
	output logic                       parity_error,
	output logic                       rejected
);

	logic    q_valid;
	logic    q_pop;
	entry_t  q_entry;
	result_t res;

	swd_front #(
		.DEPTH(QUEUE_DEPTH_P)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.ap_not_dp      (ap_not_dp),
		.read_not_write (read_not_write),
		.reg_addr       (reg_addr),
		.wr_word        (wr_word),
		.sampled_bit    (sampled_bit),
		.q_valid        (q_valid),
		.q_entry        (q_entry),
		.q_pop          (q_pop)
	);

	swd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign drive_bit    = res.drive_bit;
	assign drive_enable = res.drive_enable;
	assign clock_active = res.clock_active;
	assign busy_res     = res.busy_res;
	assign done_res     = res.done_res;
	assign ack_code     = res.ack_code;
	assign rd_word      = res.rd_word;
	assign parity_error = res.parity_error;
	assign rejected     = res.rejected;

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the SWD host engine: drives ticks and requests, predicts each line state.
`timescale 1ns / 100ps

import swd_pkg::*;

typedef struct {
	kind_t       op;
	logic        ap;
	logic        rnw;
	logic [1:0]  ra;
	logic [31:0] wd;
	logic        s;
} line_item_t;

class swd_line_scoreboard;
	phase_t             ph;
	logic [CNT_W-1:0]   cnt;
	logic [7:0]         hdr;
	logic [31:0]        word;
	logic               par;
	logic [2:0]         ack;
	logic               rd_txn;
	logic [HIGH_W-1:0]  high_len;
	logic [IDLE_W-1:0]  idle_len;
	result_t            expected_lines[$];
	int                 errors;
	int                 results_seen;

	function new();
		ph = PH_IDLE;
		cnt = '0;
		hdr = '0;
		word = '0;
		par = 1'b0;
		ack = '0;
		rd_txn = 1'b0;
		high_len = HIGH_RESET;
		idle_len = IDLE_RESET;
		errors = 0;
		results_seen = 0;
	endfunction

	function void configure(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		if (idx == CFG_HIGH_RUN)
			high_len = v[HIGH_W-1:0];
		else
			idle_len = v[IDLE_W-1:0];
	endfunction

	// {level, enable} presented on SWDIO in the current phase
	function logic [1:0] line_level();
		case (ph)
		PH_HDR:   return {hdr[0], 1'b1};
		PH_WDATA: return {word[0], 1'b1};
		PH_WPAR:  return {par, 1'b1};
		PH_LRH:   return 2'b11;
		PH_TRN1, PH_ACK, PH_TRN2, PH_RDATA, PH_RPAR, PH_TRNEND: return 2'b00;
		default:  return 2'b01;
		endcase
	endfunction

	function result_t advance_engine(line_item_t it);
		result_t            r;
		logic [HIGH_W-1:0]  run;
		logic               hp;
		r = '0;
		run = (high_len < MIN_HIGH_RUN) ? MIN_HIGH_RUN : high_len;
		if (it.op == KIND_TICK && ph != PH_IDLE) begin
			r.clock_active = 1'b1;
			{r.drive_bit, r.drive_enable} = line_level();
			case (ph)
			PH_HDR: begin
				hdr = hdr >> 1;
				cnt++;
				if (cnt >= HDR_BITS) begin
					ph = PH_TRN1;
					cnt = '0;
				end
			end
			PH_TRN1: begin
				ph = PH_ACK;
				cnt = '0;
				ack = '0;
			end
			PH_ACK: begin
				ack[cnt[1:0]] = it.s;
				cnt++;
				if (cnt >= ACK_BITS) begin
					cnt = '0;
					if (ack != ACK_OK) begin
						ph = PH_TRNEND;
					end else if (rd_txn) begin
						ph = PH_RDATA;
						word = '0;
						par = 1'b0;
					end else begin
						ph = PH_TRN2;
					end
				end
			end
			PH_TRN2: begin
				ph = PH_WDATA;
				cnt = '0;
			end
			PH_WDATA: begin
				word = word >> 1;
				cnt++;
				if (cnt >= DATA_BITS) begin
					ph = PH_WPAR;
					cnt = '0;
				end
			end
			PH_WPAR: begin
				r.done_res = 1'b1;
				r.ack_code = ack;
				ph = PH_IDLE;
			end
			PH_RDATA: begin
				word = {it.s, word[31:1]};
				par ^= it.s;
				cnt++;
				if (cnt >= DATA_BITS) begin
					ph = PH_RPAR;
					cnt = '0;
				end
			end
			PH_RPAR: begin
				par ^= it.s;
				ph = PH_TRNEND;
			end
			PH_TRNEND: begin
				r.done_res = 1'b1;
				r.ack_code = ack;
				if (ack == ACK_OK && rd_txn) begin
					r.parity_error = par;
					r.rd_word = par ? '0 : word;
				end
				ph = PH_IDLE;
			end
			PH_LRH: begin
				cnt++;
				if (cnt >= run) begin
					cnt = '0;
					if (idle_len == '0) begin
						r.done_res = 1'b1;
						ph = PH_IDLE;
					end else begin
						ph = PH_LRL;
					end
				end
			end
			PH_LRL: begin
				cnt++;
				if (cnt >= {3'b000, idle_len}) begin
					cnt = '0;
					r.done_res = 1'b1;
					ph = PH_IDLE;
				end
			end
			default: ph = PH_IDLE;
			endcase
		end else begin
			if (it.op == KIND_TXN || it.op == KIND_LRST) begin
				if (ph != PH_IDLE) begin
					r.rejected = 1'b1;
				end else if (it.op == KIND_TXN) begin
					hp = it.ap ^ it.rnw ^ it.ra[0] ^ it.ra[1];
					hdr = {2'b10, hp, it.ra, it.rnw, it.ap, 1'b1};
					word = it.wd;
					par = ^it.wd;
					ack = '0;
					rd_txn = it.rnw;
					cnt = '0;
					ph = PH_HDR;
				end else begin
					hdr = '0;
					ack = '0;
					par = 1'b0;
					rd_txn = 1'b0;
					cnt = '0;
					ph = PH_LRH;
				end
			end
			{r.drive_bit, r.drive_enable} = line_level();
		end
		r.busy_res = (ph != PH_IDLE);
		return r;
	endfunction

	function void note_transfer(line_item_t it);
		expected_lines.push_back(advance_engine(it));
	endfunction

	task flag_mismatch(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	task compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	task check_transfer(result_t got);
		result_t want;
		results_seen++;
		if (expected_lines.size() == 0) begin
			flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
			return;
		end
		want = expected_lines.pop_front();
		compare_field("drive_bit", 32'(got.drive_bit), 32'(want.drive_bit));
		compare_field("drive_enable", 32'(got.drive_enable), 32'(want.drive_enable));
		compare_field("clock_active", 32'(got.clock_active), 32'(want.clock_active));
		compare_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
		compare_field("done_res", 32'(got.done_res), 32'(want.done_res));
		compare_field("ack_code", 32'(got.ack_code), 32'(want.ack_code));
		compare_field("rd_word", got.rd_word, want.rd_word);
		compare_field("parity_error", 32'(got.parity_error), 32'(want.parity_error));
		compare_field("rejected", 32'(got.rejected), 32'(want.rejected));
	endtask
endclass

module testbench;
	localparam logic [ACK_BITS-1:0] ACK_WAIT  = 3'b010;
	localparam logic [ACK_BITS-1:0] ACK_FAULT = 3'b100;
	localparam logic [ACK_BITS-1:0] ACK_NONE  = 3'b111;
	localparam logic [ACK_BITS-1:0] ACK_LOW   = 3'b000;
	localparam int ACK_AT      = HDR_BITS + 1;
	localparam int DATA_AT     = ACK_AT + ACK_BITS;
	localparam int PAR_AT      = DATA_AT + DATA_BITS;
	localparam int TICKS_FULL  = PAR_AT + 2;
	localparam int TICKS_SHORT = DATA_AT + 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            kind = KIND_TICK;
	logic                  ap_not_dp = 1'b0;
	logic                  read_not_write = 1'b0;
	logic [1:0]            reg_addr = '0;
	logic [DATA_BITS-1:0]  wr_word = '0;
	logic                  sampled_bit = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  drive_bit;
	logic                  drive_enable;
	logic                  clock_active;
	logic                  busy_res;
	logic                  done_res;
	logic [ACK_BITS-1:0]   ack_code;
	logic [DATA_BITS-1:0]  rd_word;
	logic                  parity_error;
	logic                  rejected;

	swd_line_scoreboard sb;
	line_item_t         stim[$];
	line_item_t         cur;
	int                 pushed = 0;
	int                 useful = 0;
	int                 accepted = 0;
	int                 quiet = 0;
	int                 hold_left = 0;
	bit                 hold_request = 1'b0;
	bit                 gaps_on = 1'b1;

	swd_host_transaction_engine_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.ap_not_dp      (ap_not_dp),
		.read_not_write (read_not_write),
		.reg_addr       (reg_addr),
		.wr_word        (wr_word),
		.sampled_bit    (sampled_bit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_bit      (drive_bit),
		.drive_enable   (drive_enable),
		.clock_active   (clock_active),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.ack_code       (ack_code),
		.rd_word        (rd_word),
		.parity_error   (parity_error),
		.rejected       (rejected)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sb.note_transfer(cur);
			accepted++;
		end
		if (!in_valid || !in_stall) begin
			if (stim.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 22)) begin
				cur = stim.pop_front();
				in_valid <= 1'b1;
				kind <= cur.op;
				ap_not_dp <= cur.ap;
				read_not_write <= cur.rnw;
				reg_addr <= cur.ra;
				wr_word <= cur.wd;
				sampled_bit <= cur.s;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_transfer(result_t'({drive_bit, drive_enable, clock_active, busy_res,
				done_res, ack_code, rd_word, parity_error, rejected}));
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= gaps_on && ($urandom_range(0, 99) < 22);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic line_item_t make_item(kind_t k, logic s);
		line_item_t it;
		it.op = k;
		it.ap = 1'($urandom);
		it.rnw = 1'($urandom);
		it.ra = 2'($urandom);
		it.wd = $urandom;
		it.s = s;
		return it;
	endfunction

	function automatic void push(line_item_t it, bit counts);
		stim.push_back(it);
		pushed++;
		if (counts)
			useful++;
	endfunction

	// requests and spare kinds while busy: rejected or dropped
	function automatic void add_noise(int pct);
		if ($urandom_range(0, 99) < pct)
			push(make_item(kind_t'($urandom_range(1, 3)), 1'($urandom)), 1'b0);
	endfunction

	function automatic void queue_txn(logic ap, logic rnw, logic [1:0] ra, logic [31:0] wd,
			logic [ACK_BITS-1:0] a, logic [31:0] rd, bit par_ok, int noise_pct);
		line_item_t it;
		int         n;
		logic       s;
		it = make_item(KIND_TXN, 1'($urandom));
		it.ap = ap;
		it.rnw = rnw;
		it.ra = ra;
		it.wd = wd;
		push(it, 1'b1);
		n = (a == ACK_OK) ? TICKS_FULL : TICKS_SHORT;
		for (int k = 0; k < n; k++) begin
			s = 1'($urandom);
			if (k >= ACK_AT && k < DATA_AT)
				s = a[k - ACK_AT];
			else if (rnw && a == ACK_OK && k >= DATA_AT && k < PAR_AT)
				s = rd[k - DATA_AT];
			else if (rnw && a == ACK_OK && k == PAR_AT)
				s = (^rd) ^ !par_ok;
			add_noise(noise_pct);
			push(make_item(KIND_TICK, s), 1'b1);
		end
	endfunction

	function automatic void queue_line_reset(int noise_pct);
		int n;
		n = ((sb.high_len < MIN_HIGH_RUN) ? MIN_HIGH_RUN : sb.high_len) + sb.idle_len;
		push(make_item(KIND_LRST, 1'($urandom)), 1'b1);
		for (int k = 0; k < n; k++) begin
			add_noise(noise_pct);
			push(make_item(KIND_TICK, 1'($urandom)), 1'b1);
		end
	endfunction

	function automatic void random_txn(int noise_pct);
		logic [ACK_BITS-1:0] a;
		int                  p;
		p = $urandom_range(0, 99);
		if (p < 75)
			a = ACK_OK;
		else if (p < 83)
			a = ACK_WAIT;
		else if (p < 90)
			a = ACK_FAULT;
		else
			a = 3'($urandom);
		queue_txn(1'($urandom), 1'($urandom), 2'($urandom), $urandom, a, $urandom,
			$urandom_range(0, 9) != 0, noise_pct);
	endfunction

	function automatic void queue_traffic(int budget, int noise_pct);
		int stop;
		int pick;
		stop = useful + budget;
		while (useful < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				queue_line_reset(noise_pct);
			end else if (pick < 13) begin
				repeat ($urandom_range(1, 3))
					push(make_item($urandom_range(0, 1) ? KIND_TICK : KIND_SPARE,
						1'($urandom)), 1'b0);
			end else begin
				random_txn(noise_pct);
			end
		end
	endfunction

	task automatic settle();
		while (accepted != pushed || sb.expected_lines.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] l);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HIGH_RUN;
		cfg_data <= h;
		@(posedge clk);
		sb.configure(CFG_HIGH_RUN, h);
		cfg_index <= CFG_IDLE_RUN;
		cfg_data <= l;
		@(posedge clk);
		sb.configure(CFG_IDLE_RUN, l);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] run_cfg [5];
		logic [CFG_DATA_W-1:0] idle_cfg [5];
		logic [CFG_DATA_W-1:0] h;
		logic [CFG_DATA_W-1:0] l;
		run_cfg = '{7'd127, 7'd50, 7'd49, 7'd0, 7'd0};
		idle_cfg = '{7'd15, 7'd0, 7'h71, 7'h70, 7'd0};
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		push(make_item(KIND_TICK, 1'b1), 1'b0);
		push(make_item(KIND_SPARE, 1'b0), 1'b0);
		queue_txn(1'b0, 1'b0, 2'd0, 32'h0000_0000, ACK_OK, '0, 1'b1, 0);
		queue_txn(1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, ACK_OK, '0, 1'b1, 20);
		queue_txn(1'b0, 1'b1, 2'd1, '0, ACK_OK, 32'hFFFF_FFFF, 1'b1, 0);
		queue_txn(1'b1, 1'b1, 2'd2, '0, ACK_OK, 32'h8000_0001, 1'b0, 0);
		queue_txn(1'b0, 1'b1, 2'd0, '0, ACK_WAIT, '0, 1'b1, 0);
		queue_txn(1'b1, 1'b0, 2'd1, 32'hA5A5_5A5A, ACK_FAULT, '0, 1'b1, 0);
		queue_txn(1'b1, 1'b1, 2'd3, '0, ACK_NONE, '0, 1'b1, 0);
		queue_txn(1'b0, 1'b0, 2'd2, 32'h1234_5678, ACK_LOW, '0, 1'b1, 0);
		queue_line_reset(10);
		settle();

		for (int p = 0; p < 5; p++) begin
			h = run_cfg[p];
			l = idle_cfg[p];
			if (p == 4) begin
				h = 7'($urandom);
				l = 7'($urandom);
			end
			write_regs(h, l);
			gaps_on = (p != 1);
			if (p == 2)
				hold_request = 1'b1;
			queue_line_reset(5);
			queue_traffic(65, 5);
			settle();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_lines.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
